@@ hw/rtl/terr_pkg.sv @@
// Package for the trace event ring recorder: op codes, stat selectors, widths.
// Used by the top level and the checker; no dependencies.
package terr_pkg;
    localparam int DepthDefault = 64;
    localparam int InW          = 416;  // packed input tdata bits
    localparam int OutW         = 424;  // packed output tdata bits (417 used)

    localparam logic [1:0] OpEmit   = 2'd0;
    localparam logic [1:0] OpRdSeq  = 2'd1;
    localparam logic [1:0] OpRdChr  = 2'd2;
    localparam logic [1:0] OpStat   = 2'd3;

    localparam logic [63:0] StEmitted = 64'd0;
    localparam logic [63:0] StOver    = 64'd1;
    localparam logic [63:0] StDrop    = 64'd2;
    localparam logic [63:0] StRetain  = 64'd3;
    localparam logic [63:0] StNext    = 64'd4;

    // stored slot payload: seq + event fields
    localparam int SlotW = 64 + 64 + 64 + 32 + 64 + 64 + 64;
endpackage

@@ hw/rtl/terr_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module terr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/trace_event_ring_recorder.sv @@
// Trace event ring recorder top level: sequencer around one slot RAM.
// Depends on terr_pkg and terr_ram.
//
// Usage: one request word enters on the s_axis group, one result word leaves
// on m_axis for each request. tuser carries op (0 emit, 1 read by sequence,
// 2 read by chronological index, 3 statistic). The cfg channel writes
// ring_enable (reset 1); write it only while no request is in work.
// DEPTH must be a power of two: the slot is the low bits of the sequence.
// Emit, read by sequence and the counter statistics pass one state (S_LOOK or
// S_WALK) and S_DONE, which registers the result onto m_axis; tready comes
// back in the same cycle as the result. Chronological read and the retained
// count walk the window one slot per cycle through the RAM read port, then
// go to S_DONE.
// One request is in work at a time. A result waiting on a stalled receiver
// sits in the output register while the next request is worked; that next
// result then waits inside the block with tready low until the output
// register frees up.
// Reset clears counters and slot valid bits (flip-flops);
// the slot data RAM is not cleared.
module trace_event_ring_recorder #(
    parameter int DEPTH = terr_pkg::DepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target, layout_ver, rec_len, event_type, status_code, producer,
    // timestamp, frame_number, callback_number, worker_number, payload
    input  logic [terr_pkg::InW-1:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // op
    // ok, event_sequence, out_layout_ver, out_rec_len, out_event_type,
    // out_status_code, out_producer, out_timestamp, out_frame_number,
    // out_callback_number, out_worker_number, out_payload, zero pad
    output logic [terr_pkg::OutW-1:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam logic [63:0] DepthL = 64'(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_WALK, S_DONE} t_state;

    t_state r_state;
    logic [1:0]  r_op;
    logic [63:0] r_target;
    logic [351:0] r_ev;
    logic [63:0] r_next, r_emit, r_over, r_drop;
    logic        r_en;
    logic [DEPTH-1:0] r_valid;
    logic [63:0] r_q, r_found;
    logic        r_qv;      // RAM output holds the slot read for r_qrd
    logic [63:0] r_qrd;     // sequence of data at RAM output
    logic [AW-1:0] r_raddr; // slot of data at RAM output
    logic        r_obusy;
    logic [terr_pkg::OutW-1:0] r_res;  // finished result, waits for r_out
    logic [terr_pkg::OutW-1:0] r_out;

    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [terr_pkg::SlotW-1:0] w_wdata, w_rdata;
    logic [63:0] w_rseq;
    logic        w_hit;
    logic [63:0] w_wstart;

    function automatic logic [AW-1:0] slot_of(input logic [63:0] s);
        return (DEPTH > 1) ? s[AW-1:0] : '0;
    endfunction

    // result word from slot data
    function automatic logic [terr_pkg::OutW-1:0] mk_ev(
        input logic [terr_pkg::SlotW-1:0] d);
        logic [63:0] sm, sc, tm, fr, va, sq;
        logic [31:0] wk;
        sq = d[415:352]; va = d[351:288]; tm = d[287:224]; fr = d[223:160];
        wk = d[159:128]; sc = d[127:64]; sm = d[63:0];
        return terr_pkg::OutW'({va, wk, sc[63:32], fr, tm, sm[63:48], sc[31:0],
                                sm[47:32], sm[31:16], sm[15:0], sq, 1'b1});
    endfunction

    // statistic result: ok set, value in the payload field
    function automatic logic [terr_pkg::OutW-1:0] mk_stat(input logic [63:0] v);
        return terr_pkg::OutW'({v, 352'd0, 1'b1});
    endfunction

    terr_ram #(.Width(terr_pkg::SlotW), .Depth(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // slot layout: seq | value | time | frame | worker | stat_cb | small
    assign w_rseq = w_rdata[terr_pkg::SlotW-1 -: 64];
    assign w_hit  = r_en && r_valid[r_raddr] && (w_rseq == r_qrd);

    assign w_wstart = (r_next > DepthL) ? r_next - DepthL : 64'd0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_obusy;
    assign m_axis_tdata  = r_out;

    // the RAM address is taken at the same edge that r_raddr/r_qrd record it
    assign w_raddr = (r_state == S_IDLE) ? slot_of(s_axis_tdata[63:0]) : slot_of(r_q);
    assign w_we    = (r_state == S_LOOK) && (r_op == terr_pkg::OpEmit) && r_en;
    assign w_waddr = r_raddr;
    // event fields in r_ev (low first): sv, rs, et, sc(32), pr, ts, fr, cb, wk, pl
    assign w_wdata = {r_qrd, r_ev[351:288], r_ev[159:96], r_ev[223:160],
                      r_ev[287:256], r_ev[255:224], r_ev[79:48],
                      r_ev[95:80], r_ev[47:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next <= '0; r_emit <= '0; r_over <= '0; r_drop <= '0;
            r_en <= 1'b1; r_valid <= '0; r_obusy <= 1'b0; r_qv <= 1'b0;
        end else begin
            if (i_cfg_valid) r_en <= i_cfg_data;
            if (r_state == S_DONE && (!r_obusy || m_axis_tready)) r_obusy <= 1'b1;
            else if (m_axis_tready) r_obusy <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op <= s_axis_tuser;
                    r_target <= s_axis_tdata[63:0];
                    r_ev <= s_axis_tdata[terr_pkg::InW-1:64];
                    r_res <= '0;
                    case (s_axis_tuser)
                        terr_pkg::OpEmit: begin
                            r_qrd <= r_next; r_raddr <= slot_of(r_next);
                            r_next <= r_next + 64'd1;
                            r_state <= S_LOOK;
                        end
                        terr_pkg::OpRdSeq: begin
                            r_qrd <= s_axis_tdata[63:0];
                            r_raddr <= w_raddr;
                            r_state <= S_LOOK;
                        end
                        terr_pkg::OpRdChr, terr_pkg::OpStat: begin
                            r_q <= w_wstart; r_found <= '0; r_qv <= 1'b0;
                            r_state <= S_WALK;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_LOOK: begin
                    if (r_op == terr_pkg::OpEmit) begin
                        r_res <= terr_pkg::OutW'({r_qrd, r_en});
                        if (!r_en) r_drop <= r_drop + 64'd1;
                        else begin
                            r_emit <= r_emit + 64'd1;
                            if (r_valid[r_raddr]) r_over <= r_over + 64'd1;
                            r_valid[r_raddr] <= 1'b1;
                        end
                    end else if (w_hit) r_res <= mk_ev(w_rdata);
                    r_state <= S_DONE;
                end
                S_WALK: begin
                    if (r_op == terr_pkg::OpStat && r_target != terr_pkg::StRetain) begin
                        case (r_target)
                            terr_pkg::StEmitted: r_res <= mk_stat(r_emit);
                            terr_pkg::StOver:    r_res <= mk_stat(r_over);
                            terr_pkg::StDrop:    r_res <= mk_stat(r_drop);
                            terr_pkg::StNext:    r_res <= mk_stat(r_next);
                            default:             r_res <= '0;
                        endcase
                        r_state <= S_DONE;
                    end else begin
                        // pipelined: issue r_q, check previous at RAM output
                        if (r_qv && w_hit && r_op == terr_pkg::OpRdChr
                            && r_found == r_target) begin
                            r_res <= mk_ev(w_rdata);
                            r_state <= S_DONE;
                        end else if (!r_qv && !(r_q < r_next)) begin
                            if (r_op == terr_pkg::OpStat) r_res <= mk_stat(r_found);
                            r_state <= S_DONE;
                        end else if (r_qv && w_hit) begin
                            r_found <= r_found + 64'd1;
                        end
                        if (r_q < r_next) begin
                            r_raddr <= w_raddr; r_qrd <= r_q;
                            r_q <= r_q + 64'd1; r_qv <= 1'b1;
                        end else r_qv <= 1'b0;
                    end
                end
                S_DONE: if (!r_obusy || m_axis_tready) begin
                    r_out <= r_res;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/terr_checker.sv @@
// Port-level checker for the trace event ring recorder, bound to the top.
// Depends on terr_pkg and the top level's ports.
module terr_checker (
    input logic i_clk, i_rst_n,
    input logic s_axis_tvalid, s_axis_tready,
    input logic m_axis_tvalid, m_axis_tready,
    input logic [terr_pkg::OutW-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one in work");
    // a word without ok carries at most the sequence of a dropped emit
    a_fail0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[terr_pkg::OutW-1:65] == '0)
        else $error("failed result not cleared");
endmodule

bind trace_event_ring_recorder terr_checker u_chk (.*);
